// ===== hdl/skm_pkg.sv =====
// ----------------------------------------------------------------------------
// Swerve module kinematics package
// Shared widths, CORDIC constants and register indexes for the swerve
// module kinematics datapath.
// ----------------------------------------------------------------------------
package skm_pkg;

    // CORDIC iterations, one pipeline stage each.
    localparam int ITER = 16;

    // Angle accumulator: 2^20 units per turn, with headroom and sign.
    localparam int ANG_W = 22;

    // Rotation CORDIC datapath (translation rotated into the robot frame).
    localparam int ROT_W = 27;

    // Wheel velocity components, Q.16 metres per second.
    localparam int WV_W = 26;

    // Vectoring CORDIC datapath.
    localparam int VEC_W = 28;

    // Wheel speed magnitude, Q.16 metres per second, unsigned.
    localparam int MAG_W = 25;

    // Wheel offset from the centre of rotation, mm/256.
    localparam int R_W = 22;

    // Turn contribution to a wheel velocity component.
    localparam int TT_W = 24;

    // Quotient bits of the speed scaling divider.
    localparam int QB_W = 15;

    // Register stages inside the vectoring unit.
    localparam int VEC_LAT = ITER + 3;

    localparam logic signed [ANG_W-1:0] FULL_TURN    = 22'sd1048576;
    localparam logic signed [ANG_W-1:0] HALF_TURN    = 22'sd524288;
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = 22'sd262144;

    // Reciprocal of the CORDIC gain, Q.16.
    localparam logic [15:0] INV_GAIN = 16'd39797;

    // ceil(2^35 / 125), exact for the dividend range in use.
    localparam logic [28:0] RECIP_125 = 29'd274877907;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEADBAND    = 2'd0;
    localparam logic [1:0] REG_MAX_SPEED   = 2'd1;
    localparam logic [1:0] REG_WHEEL_BASE  = 2'd2;
    localparam logic [1:0] REG_TRACK_WIDTH = 2'd3;

    // Arctangent of 2^-idx in 2^20 units per turn.
    function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
        logic signed [ANG_W-1:0] r;
        unique case (idx)
            0:       r = 22'sd131072;
            1:       r = 22'sd77376;
            2:       r = 22'sd40884;
            3:       r = 22'sd20753;
            4:       r = 22'sd10417;
            5:       r = 22'sd5213;
            6:       r = 22'sd2607;
            7:       r = 22'sd1304;
            8:       r = 22'sd652;
            9:       r = 22'sd326;
            10:      r = 22'sd163;
            11:      r = 22'sd81;
            12:      r = 22'sd41;
            13:      r = 22'sd20;
            14:      r = 22'sd10;
            default: r = 22'sd5;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/skm_vector.sv =====
// ----------------------------------------------------------------------------
// Swerve module kinematics vectoring unit
// Pipelined CORDIC that turns one wheel velocity vector into a steering
// angle and a gain-corrected speed magnitude.
// ----------------------------------------------------------------------------
module skm_vector (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [skm_pkg::WV_W-1:0]  x_in,
    input  logic signed [skm_pkg::WV_W-1:0]  y_in,
    output logic [15:0]                      ang_out,
    output logic [skm_pkg::MAG_W-1:0]        mag_out
);
    import skm_pkg::*;

    logic signed [VEC_W-1:0] x_reg [0:ITER];
    logic signed [VEC_W-1:0] y_reg [0:ITER];
    logic signed [ANG_W-1:0] z_reg [0:ITER];
    logic                    zero_reg [0:ITER+2];
    logic [VEC_W+14:0]       prod_reg;
    logic [15:0]             ang_reg;
    logic [15:0]             ang_out_reg;
    logic [MAG_W-1:0]        mag_out_reg;

    logic signed [ANG_W-1:0] z_rnd;
    logic [VEC_W+15:0]       mag_rnd;

    // Angle rounded to 16 bits, taken modulo one turn.
    assign z_rnd   = z_reg[ITER] + 22'sd8;
    assign mag_rnd = {1'b0, prod_reg} + (VEC_W+16)'(32768);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // A vector in the left half plane is turned round by half a turn.
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                x_reg[0] <= -VEC_W'(x_in);
                y_reg[0] <= -VEC_W'(y_in);
                z_reg[0] <= HALF_TURN;
            end
            else
            begin
                x_reg[0] <= VEC_W'(x_in);
                y_reg[0] <= VEC_W'(y_in);
                z_reg[0] <= '0;
            end

            for (int i = 0; i < ITER; i++)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_step(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_step(i);
                end
                zero_reg[i+1] <= zero_reg[i];
            end

            // The final x is never negative, so the gain product is unsigned.
            prod_reg           <= (VEC_W+15)'(x_reg[ITER][VEC_W-2:0]) * (VEC_W+15)'(INV_GAIN);
            ang_reg            <= z_rnd[19:4];
            zero_reg[ITER+1]   <= zero_reg[ITER];

            mag_out_reg        <= zero_reg[ITER+1] ? '0 : mag_rnd[16 +: MAG_W];
            ang_out_reg        <= zero_reg[ITER+1] ? '0 : ang_reg;
            zero_reg[ITER+2]   <= zero_reg[ITER+1];
        end
    end

    assign ang_out = ang_out_reg;
    assign mag_out = mag_out_reg;

endmodule

// ===== hdl/swerve_module_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// Swerve module kinematics
// Four-wheel swerve drive inverse kinematics: drive command in, steering
// angle and speed for each of the four wheels out.
// ----------------------------------------------------------------------------
// Usage:
// A drive command word is taken on the input channel (in_valid/in_ready) and
// exactly one result word leaves on the output channel (out_valid/out_ready).
// The datapath is a single pipeline of 58 register stages plus the output
// register, and one command can be taken in every cycle while the receiver
// does not stall; the depth is set by the two 16-step CORDIC chains and the
// 15-step speed scaling divider in series. When the receiver stalls, the
// whole pipeline holds still and in_ready falls only while the output
// register is full and out_ready is low, so nothing is lost or repeated. The
// four configuration registers are written through the cfg channel, which is
// always ready; they should be changed only while the pipeline is empty.
// Reset empties the pipeline and loads the register reset values (deadband
// 13, max speed 1024, wheel base and track width 600 mm).
// ----------------------------------------------------------------------------
module swerve_module_kinematics_top (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] forward_rate,
    input  logic signed [15:0] strafe_rate,
    input  logic signed [15:0] turn_rate,
    input  logic               field_relative,
    input  logic [15:0]        heading,
    input  logic [8:0]         pivot_x,
    input  logic [8:0]         pivot_y,

    output logic               out_valid,
    input  logic               out_ready,
    output logic               stopped,
    output logic [15:0]        fl_angle,
    output logic [15:0]        fl_speed,
    output logic [15:0]        fr_angle,
    output logic [15:0]        fr_speed,
    output logic [15:0]        bl_angle,
    output logic [15:0]        bl_speed,
    output logic [15:0]        br_angle,
    output logic [15:0]        br_speed,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_data
);
    import skm_pkg::*;

    // Stage map of the pipeline.
    localparam int S_TT      = 4;                 // turn terms ready
    localparam int S_GAIN    = ITER + 1;          // rotation gain product
    localparam int S_RND     = ITER + 2;          // rotated translation
    localparam int S_WHEEL   = ITER + 3;          // wheel velocities
    localparam int S_VEC_OUT = S_WHEEL + VEC_LAT; // angle and magnitude
    localparam int S_PAIR    = S_VEC_OUT + 1;     // pairwise maxima
    localparam int S_MAX     = S_PAIR + 1;        // largest magnitude
    localparam int S_PROD    = S_MAX + 1;         // magnitude times limit
    localparam int S_NUM     = S_PROD + 1;        // rounded dividend
    localparam int S_DIV0    = S_NUM + 1;         // first divider step
    localparam int S_LAST    = S_DIV0 + QB_W - 1; // last divider step
    localparam int GP_W      = ROT_W + 17;        // rotation gain product
    localparam int NUM_W     = MAG_W + 16;        // divider dividend

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [14:0] deadband_reg;
    logic [14:0] max_speed_reg;
    logic [10:0] wheel_base_reg;
    logic [10:0] track_width_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg    <= 15'd13;
            max_speed_reg   <= 15'd1024;
            wheel_base_reg  <= 11'd600;
            track_width_reg <= 11'd600;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEADBAND:    deadband_reg    <= cfg_data;
                REG_MAX_SPEED:   max_speed_reg   <= cfg_data;
                REG_WHEEL_BASE:  wheel_base_reg  <= cfg_data[10:0];
                REG_TRACK_WIDTH: track_width_reg <= cfg_data[10:0];
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control: every stage moves together, held while the output
    // register is full and not being taken.
    // ------------------------------------------------------------------
    logic              adv;
    logic [S_LAST:0]   vld_reg;
    logic              out_valid_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[S_LAST-1:0], in_valid};
            out_valid_reg <= vld_reg[S_LAST];
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Entry stage: deadband test, rotation set-up and wheel offsets.
    // ------------------------------------------------------------------
    logic signed [16:0]      fwd_ext, str_ext, trn_ext;
    logic [16:0]             fwd_abs, str_abs, trn_abs;
    logic                    stop_next;
    logic [15:0]             neg_head;
    logic signed [ANG_W-1:0] z_wrap, z_fold;
    logic                    flip;
    logic signed [ROT_W-1:0] vx_in, vy_in;
    logic signed [11:0]      wb_s, tw_s;
    logic signed [10:0]      px_s, py_s;
    logic signed [R_W-1:0]   rad_next [4];

    always_comb
    begin
        fwd_ext = 17'(forward_rate);
        str_ext = 17'(strafe_rate);
        trn_ext = 17'(turn_rate);
        fwd_abs = fwd_ext[16] ? 17'(-fwd_ext) : 17'(fwd_ext);
        str_abs = str_ext[16] ? 17'(-str_ext) : 17'(str_ext);
        trn_abs = trn_ext[16] ? 17'(-trn_ext) : 17'(trn_ext);
        stop_next = (fwd_abs < {2'b00, deadband_reg}) &&
                    (str_abs < {2'b00, deadband_reg}) &&
                    (trn_abs < {2'b00, deadband_reg});

        // Field frame to robot frame: rotate by minus the heading. Angles
        // beyond a quarter turn are folded back by negating the vector.
        neg_head = 16'(16'd0 - heading);
        z_wrap   = $signed({2'b00, neg_head, 4'b0000});
        if (z_wrap >= HALF_TURN)
        begin
            z_wrap = z_wrap - FULL_TURN;
        end
        flip = (z_wrap > QUARTER_TURN) || (z_wrap < -QUARTER_TURN);
        if (flip)
        begin
            z_fold = (z_wrap > 0) ? z_wrap - HALF_TURN : z_wrap + HALF_TURN;
        end
        else
        begin
            z_fold = z_wrap;
        end
        vx_in = ROT_W'($signed({forward_rate, 8'h00}));
        vy_in = ROT_W'($signed({strafe_rate, 8'h00}));

        // Wheel offsets from the centre of rotation, mm/256, in the order
        // front, rear (along the length), left, right (across the width).
        wb_s = $signed({1'b0, wheel_base_reg});
        tw_s = $signed({1'b0, track_width_reg});
        px_s = $signed({2'b00, pivot_x});
        py_s = $signed({2'b00, pivot_y});
        rad_next[0] = R_W'(wb_s) * R_W'(11'sd256 - px_s);
        rad_next[1] = -(R_W'(wb_s) * R_W'(px_s));
        rad_next[2] = R_W'(tw_s) * R_W'(11'sd256 - py_s);
        rad_next[3] = -(R_W'(tw_s) * R_W'(py_s));
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    logic                    stop_reg  [0:S_LAST];
    logic                    rot_reg   [0:S_GAIN];
    logic signed [23:0]      raw_x_reg [0:S_GAIN];
    logic signed [23:0]      raw_y_reg [0:S_GAIN];

    logic signed [ROT_W-1:0] ra_reg [0:ITER];
    logic signed [ROT_W-1:0] rb_reg [0:ITER];
    logic signed [ANG_W-1:0] rz_reg [0:ITER];
    logic signed [GP_W-1:0]  ga_reg, gb_reg;
    logic signed [WV_W-1:0]  vx_reg, vy_reg;

    logic signed [15:0]      turn0_reg;
    logic signed [R_W-1:0]   rad_reg   [4];
    logic signed [37:0]      tprod_reg [4];
    logic [29:0]             tm_reg    [4];
    logic [58:0]             tq_reg    [4];
    logic                    tneg_reg  [2:3][4];
    logic signed [TT_W-1:0]  tt_reg    [S_TT:S_RND][4];

    logic signed [WV_W-1:0]  wx_reg [4];
    logic signed [WV_W-1:0]  wy_reg [4];
    logic [15:0]             v_ang  [4];
    logic [MAG_W-1:0]        v_mag  [4];

    logic [MAG_W-1:0]        pair_reg [2];
    logic [MAG_W-1:0]        mag_reg  [S_PAIR:S_MAX][4];
    logic [15:0]             ang_reg  [S_PAIR:S_LAST][4];
    logic [MAG_W-1:0]        maxmag_reg;
    logic [MAG_W-1:0]        den_reg  [S_PROD:S_LAST];
    logic                    scale_reg [S_MAX:S_LAST];
    logic [15:0]             plain_reg [S_PROD:S_LAST][4];
    logic [MAG_W+14:0]       mprod_reg [4];
    logic [NUM_W-1:0]        num_reg  [S_NUM:S_LAST][4];
    logic [QB_W-1:0]         quo_reg  [S_DIV0:S_LAST][4];

    logic                    out_stop_reg;
    logic [15:0]             out_ang_reg [4];
    logic [15:0]             out_spd_reg [4];

    // Combinational helpers between stages.
    logic [35:0]             tabs [4];
    logic signed [WV_W-1:0]  rot_x_next, rot_y_next;
    logic [MAG_W-1:0]        max_next;
    logic [MAG_W:0]          plain_sum [4];
    logic [NUM_W-1:0]        sub_shift [S_DIV0:S_LAST][4];
    logic                    sub_ok    [S_DIV0:S_LAST][4];
    logic [NUM_W-1:0]        num_prev  [S_DIV0:S_LAST][4];
    logic [QB_W-1:0]         quo_prev  [S_DIV0:S_LAST][4];
    logic [16:0]             spd_next  [4];

    // Gain correction with rounding half away from zero.
    function automatic logic signed [WV_W-1:0] gain_round(input logic signed [GP_W-1:0] p);
        logic [GP_W-1:0] pa;
        logic [GP_W-1:0] rs;
        pa = p[GP_W-1] ? GP_W'(-p) : GP_W'(p);
        rs = pa + GP_W'(32768);
        return p[GP_W-1] ? -$signed(rs[16 +: WV_W]) : $signed(rs[16 +: WV_W]);
    endfunction

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            tabs[k] = tprod_reg[k][37] ? 36'(-tprod_reg[k]) : 36'(tprod_reg[k]);
            plain_sum[k] = {1'b0, mag_reg[S_MAX][k]} + (MAG_W+1)'(128);
        end

        rot_x_next = rot_reg[S_GAIN] ? gain_round(ga_reg) : WV_W'(raw_x_reg[S_GAIN]);
        rot_y_next = rot_reg[S_GAIN] ? gain_round(gb_reg) : WV_W'(raw_y_reg[S_GAIN]);

        max_next = (pair_reg[0] > pair_reg[1]) ? pair_reg[0] : pair_reg[1];

        // Restoring division, one quotient bit per stage, most significant
        // bit first.
        for (int s = S_DIV0; s <= S_LAST; s++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                num_prev[s][k]  = (s == S_DIV0) ? num_reg[S_NUM][k] : num_reg[s-1][k];
                quo_prev[s][k]  = (s == S_DIV0) ? '0 : quo_reg[s-1][k];
                sub_shift[s][k] = NUM_W'(den_reg[s-1]) << (S_LAST - s);
                sub_ok[s][k]    = num_prev[s][k] >= sub_shift[s][k];
            end
        end

        for (int k = 0; k < 4; k++)
        begin
            if (stop_reg[S_LAST])
            begin
                spd_next[k] = '0;
            end
            else if (scale_reg[S_LAST])
            begin
                spd_next[k] = 17'(quo_reg[S_LAST][k]);
            end
            else
            begin
                spd_next[k] = {1'b0, plain_reg[S_LAST][k]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Entry stage.
            stop_reg[0]  <= stop_next;
            rot_reg[0]   <= field_relative;
            raw_x_reg[0] <= $signed({forward_rate, 8'h00});
            raw_y_reg[0] <= $signed({strafe_rate, 8'h00});
            ra_reg[0]    <= flip ? -vx_in : vx_in;
            rb_reg[0]    <= flip ? -vy_in : vy_in;
            rz_reg[0]    <= z_fold;
            turn0_reg    <= turn_rate;
            for (int k = 0; k < 4; k++)
            begin
                rad_reg[k] <= rad_next[k];
            end

            for (int s = 1; s <= S_LAST; s++)
            begin
                stop_reg[s] <= stop_reg[s-1];
            end
            for (int s = 1; s <= S_GAIN; s++)
            begin
                rot_reg[s]   <= rot_reg[s-1];
                raw_x_reg[s] <= raw_x_reg[s-1];
                raw_y_reg[s] <= raw_y_reg[s-1];
            end

            // Rotation CORDIC, one iteration per stage.
            for (int i = 0; i < ITER; i++)
            begin
                if (rz_reg[i] >= 0)
                begin
                    ra_reg[i+1] <= ra_reg[i] - (rb_reg[i] >>> i);
                    rb_reg[i+1] <= rb_reg[i] + (ra_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] - atan_step(i);
                end
                else
                begin
                    ra_reg[i+1] <= ra_reg[i] + (rb_reg[i] >>> i);
                    rb_reg[i+1] <= rb_reg[i] - (ra_reg[i] >>> i);
                    rz_reg[i+1] <= rz_reg[i] + atan_step(i);
                end
            end
            ga_reg <= GP_W'(ra_reg[ITER]) * GP_W'($signed({1'b0, INV_GAIN}));
            gb_reg <= GP_W'(rb_reg[ITER]) * GP_W'($signed({1'b0, INV_GAIN}));
            vx_reg <= rot_x_next;
            vy_reg <= rot_y_next;

            // Turn terms: turn rate times offset over 8000, rounded half
            // away from zero. The division is a shift by 64 and a
            // reciprocal multiply for the remaining 125.
            for (int k = 0; k < 4; k++)
            begin
                tprod_reg[k]      <= 38'(turn0_reg) * 38'(rad_reg[k]);
                tneg_reg[2][k]    <= tprod_reg[k][37];
                tm_reg[k]         <= 30'((tabs[k] + 36'd4000) >> 6);
                tneg_reg[3][k]    <= tneg_reg[2][k];
                tq_reg[k]         <= 59'(tm_reg[k]) * 59'(RECIP_125);
                tt_reg[S_TT][k]   <= tneg_reg[3][k] ? -$signed(tq_reg[k][58:35])
                                                    :  $signed(tq_reg[k][58:35]);
                for (int s = S_TT + 1; s <= S_RND; s++)
                begin
                    tt_reg[s][k] <= tt_reg[s-1][k];
                end
            end

            // Wheel velocities by the rigid-body rule. Turn terms are
            // indexed front, rear, left, right.
            wx_reg[0] <= vx_reg - WV_W'(tt_reg[S_RND][2]);
            wy_reg[0] <= vy_reg + WV_W'(tt_reg[S_RND][0]);
            wx_reg[1] <= vx_reg - WV_W'(tt_reg[S_RND][3]);
            wy_reg[1] <= vy_reg + WV_W'(tt_reg[S_RND][0]);
            wx_reg[2] <= vx_reg - WV_W'(tt_reg[S_RND][2]);
            wy_reg[2] <= vy_reg + WV_W'(tt_reg[S_RND][1]);
            wx_reg[3] <= vx_reg - WV_W'(tt_reg[S_RND][3]);
            wy_reg[3] <= vy_reg + WV_W'(tt_reg[S_RND][1]);

            // Largest magnitude through a two-level registered tree.
            pair_reg[0] <= (v_mag[0] > v_mag[1]) ? v_mag[0] : v_mag[1];
            pair_reg[1] <= (v_mag[2] > v_mag[3]) ? v_mag[2] : v_mag[3];
            maxmag_reg  <= max_next;
            scale_reg[S_MAX] <= max_next > {2'b00, max_speed_reg, 8'h00};
            for (int s = S_MAX + 1; s <= S_LAST; s++)
            begin
                scale_reg[s] <= scale_reg[s-1];
            end
            den_reg[S_PROD] <= maxmag_reg;
            for (int s = S_PROD + 1; s <= S_LAST; s++)
            begin
                den_reg[s] <= den_reg[s-1];
            end

            for (int k = 0; k < 4; k++)
            begin
                mag_reg[S_PAIR][k] <= v_mag[k];
                mag_reg[S_MAX][k]  <= mag_reg[S_PAIR][k];
                ang_reg[S_PAIR][k] <= v_ang[k];
                for (int s = S_PAIR + 1; s <= S_LAST; s++)
                begin
                    ang_reg[s][k] <= ang_reg[s-1][k];
                end

                // Unscaled speed: Q.16 to Q8.8 with rounding, saturated.
                plain_reg[S_PROD][k] <= (|plain_sum[k][MAG_W:24]) ? 16'hFFFF
                                                                  : plain_sum[k][23:8];
                for (int s = S_PROD + 1; s <= S_LAST; s++)
                begin
                    plain_reg[s][k] <= plain_reg[s-1][k];
                end

                // Scaled speed: magnitude times limit over the largest
                // magnitude, rounded by adding half the divisor.
                mprod_reg[k]      <= (MAG_W+15)'(mag_reg[S_MAX][k]) * (MAG_W+15)'(max_speed_reg);
                num_reg[S_NUM][k] <= NUM_W'(mprod_reg[k]) + NUM_W'(den_reg[S_PROD] >> 1);

                for (int s = S_DIV0; s <= S_LAST; s++)
                begin
                    num_reg[s][k] <= sub_ok[s][k] ? num_prev[s][k] - sub_shift[s][k]
                                                  : num_prev[s][k];
                    quo_reg[s][k] <= {quo_prev[s][k][QB_W-2:0], sub_ok[s][k]};
                end

                out_ang_reg[k] <= stop_reg[S_LAST] ? 16'h0000 : ang_reg[S_LAST][k];
                out_spd_reg[k] <= spd_next[k][15:0];
            end
            out_stop_reg <= stop_reg[S_LAST];
        end
    end

    // ------------------------------------------------------------------
    // Steering angle and speed magnitude of each wheel.
    // ------------------------------------------------------------------
    for (genvar k = 0; k < 4; k++)
    begin : g_wheel
        skm_vector u_vector (
            .clk     (clk),
            .en      (adv),
            .x_in    (wx_reg[k]),
            .y_in    (wy_reg[k]),
            .ang_out (v_ang[k]),
            .mag_out (v_mag[k])
        );
    end

    assign stopped  = out_stop_reg;
    assign fl_angle = out_ang_reg[0];
    assign fl_speed = out_spd_reg[0];
    assign fr_angle = out_ang_reg[1];
    assign fr_speed = out_spd_reg[1];
    assign bl_angle = out_ang_reg[2];
    assign bl_speed = out_spd_reg[2];
    assign br_angle = out_ang_reg[3];
    assign br_speed = out_spd_reg[3];

endmodule
